@@ design/dps_pkg.sv @@
// ----------------------------------------------------------------------------
// dps_pkg: shared types and constants for the drum pattern step sequencer
// Holds the event codes, pattern and voice codes, tempo limits, the control
// state type and the small pattern table functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned DELTA_W  = 10;
    localparam int unsigned TEMPO_W  = 9;
    localparam int unsigned DEN_W    = 10;

    // Tempo limits and the tempo after reset, in beats per minute.
    localparam int unsigned BPM_MIN   = 20;
    localparam int unsigned BPM_MAX   = 300;
    localparam int unsigned BPM_RESET = 120;
    localparam int unsigned SEC_PER_MIN = 60;

    // Event codes.
    localparam logic [FUNC_W-1:0] FN_ADVANCE      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CYCLE_BEAT   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TOGGLE_SEQ   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TOGGLE_PAUSE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_STOP         = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ADJUST_TEMPO = 3'd5;

    // Beat pattern codes.
    localparam logic [1:0] PAT_44 = 2'd0;
    localparam logic [1:0] PAT_34 = 2'd1;
    localparam logic [1:0] PAT_68 = 2'd2;
    localparam logic [1:0] PAT_24 = 2'd3;

    // Drum voice codes.
    localparam logic [1:0] V_KICK  = 2'd0;
    localparam logic [1:0] V_SNARE = 2'd1;
    localparam logic [1:0] V_HIHAT = 2'd2;
    localparam logic [1:0] V_CLICK = 2'd3;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } t_state;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Number of steps in the pattern that is playing.
    function automatic logic [2:0] pattern_len(input logic seq, input logic [1:0] pat);
        logic [2:0] len;
        if (seq) begin
            len = 3'd4;
        end else begin
            case (pat)
                PAT_44:  len = 3'd4;
                PAT_34:  len = 3'd3;
                PAT_68:  len = 3'd6;
                PAT_24:  len = 3'd2;
                default: len = 3'd4;
            endcase
        end
        return len;
    endfunction

    // Step position folded into the pattern length.
    function automatic logic [2:0] wrap_pos(input logic [2:0] pos, input logic [2:0] len);
        logic [2:0] p;
        case (len)
            3'd2: p = {2'b00, pos[0]};
            3'd4: p = {1'b0, pos[1:0]};
            3'd3: begin
                if (pos >= 3'd6) begin
                    p = pos - 3'd6;
                end else if (pos >= 3'd3) begin
                    p = pos - 3'd3;
                end else begin
                    p = pos;
                end
            end
            default: p = (pos >= 3'd6) ? pos - 3'd6 : pos;
        endcase
        return p;
    endfunction

    // Voice at a step of the pattern that is playing.
    function automatic logic [1:0] pattern_voice(input logic seq, input logic [1:0] pat,
                                                 input logic [2:0] p);
        logic [1:0] v;
        v = V_KICK;
        if (seq) begin
            case (p)
                3'd0:    v = V_KICK;
                3'd1:    v = V_SNARE;
                3'd2:    v = V_HIHAT;
                default: v = V_CLICK;
            endcase
        end else begin
            case (pat)
                PAT_44: begin
                    case (p)
                        3'd0:    v = V_KICK;
                        3'd2:    v = V_SNARE;
                        default: v = V_HIHAT;
                    endcase
                end
                PAT_34: begin
                    case (p)
                        3'd0:    v = V_KICK;
                        3'd1:    v = V_HIHAT;
                        default: v = V_SNARE;
                    endcase
                end
                PAT_68: begin
                    case (p)
                        3'd0:    v = V_KICK;
                        3'd3:    v = V_SNARE;
                        default: v = V_HIHAT;
                    endcase
                end
                default: begin
                    v = (p == 3'd0) ? V_KICK : V_SNARE;
                end
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/dps_div.sv @@
// ----------------------------------------------------------------------------
// dps_div: shared restoring divider
// Divides an unsigned numerator by an unsigned denominator, one quotient bit
// per cycle, and gives the quotient and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_div
    import dps_pkg::*;
#(
    parameter int unsigned NUM_W = 22
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output t_div_stat             o_stat,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_fits;

    // Trial subtraction of the denominator from the shifted partial remainder.
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_fits  = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(NUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Quotient shifts in from the right while the numerator shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

@@ design/drum_pattern_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// drum_pattern_step_sequencer: metronome and drum step sequencer
// Takes one event word at a time (advance, pattern cycle, mode toggles,
// stop, tempo change) and returns one status word per event, with a drum
// voice when an advance runs out the current step.
//
//   Channel  Valid        Stall        Payload
//   input    i_in_valid   o_in_stall   i_func, i_sample_count, i_delta_bpm
//   output   o_out_valid  i_out_stall  o_voice_valid, o_voice, o_pattern_now,
//                                      o_is_paused, o_is_active,
//                                      o_is_sequential, o_tempo_now
//
// An event that does not reload the step passes from ST_EXEC to ST_PUSH and
// is loaded into the output register from ST_PUSH; the input is free again
// once its word is loaded. An advance that ends a step reloads it through the
// shared bit-serial divider in ST_DIV before its word is loaded in ST_PUSH.
// One event is in work at a time; the input stalls until its word is loaded.
// Reset is synchronous and active low; it gives 120 BPM, four-four, stopped.
// A stalled output word holds, and the block waits with its next word.
// ----------------------------------------------------------------------------
`default_nettype none

module drum_pattern_step_sequencer
    import dps_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE = 48000
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic        [FUNC_W-1:0]   i_func,
    input  wire logic        [SAMPLE_W-1:0] i_sample_count,
    input  wire logic signed [DELTA_W-1:0]  i_delta_bpm,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_voice_valid,
    output logic             [1:0]          o_voice,
    output logic             [1:0]          o_pattern_now,
    output logic                            o_is_paused,
    output logic                            o_is_active,
    output logic                            o_is_sequential,
    output logic             [TEMPO_W-1:0]  o_tempo_now
);

    // Numerator is one minute of frames plus the carried remainder.
    localparam int unsigned NUM_BASE = SAMPLE_RATE * SEC_PER_MIN;
    localparam int unsigned NUM_MAX  = NUM_BASE + 2 * BPM_MAX - 1;
    localparam int unsigned NUM_W    = $clog2(NUM_MAX + 1);
    localparam int unsigned FL_W     = $clog2(NUM_MAX / BPM_MIN + 1);
    localparam int unsigned CMP_W    = (FL_W > SAMPLE_W) ? FL_W : SAMPLE_W;

    t_state                     r_state, n_state;
    logic                       r_beat_on, n_beat_on;
    logic                       r_seq_on, n_seq_on;
    logic                       r_pause, n_pause;
    logic [1:0]                 r_pattern, n_pattern;
    logic [2:0]                 r_step_pos, n_step_pos;
    logic [TEMPO_W-1:0]         r_tempo, n_tempo;
    logic [FL_W-1:0]            r_frames, n_frames;
    logic [DEN_W-1:0]           r_carry, n_carry;
    logic                       r_hit, n_hit;
    logic [1:0]                 r_voice, n_voice;

    logic [FUNC_W-1:0]          r_func;
    logic [SAMPLE_W-1:0]        r_samples;
    logic [DELTA_W-1:0]         r_delta;

    logic                       r_out_valid;
    logic                       r_o_hit;
    logic [1:0]                 r_o_voice;
    logic [1:0]                 r_o_pattern;
    logic                       r_o_pause;
    logic                       r_o_active;
    logic                       r_o_seq;
    logic [TEMPO_W-1:0]         r_o_tempo;

    logic                       w_accept;
    logic                       w_active;
    logic                       w_out_free;
    logic [2:0]                 w_len;
    logic [2:0]                 w_pos;
    logic                       w_div_start;
    logic [NUM_W-1:0]           w_num;
    logic [DEN_W-1:0]           w_den;
    logic signed [TEMPO_W+2:0]  w_tsum;
    t_div_stat                  w_div_stat;
    logic [NUM_W-1:0]           w_quo;
    logic [DEN_W-1:0]           w_rem;
    logic [FL_W-1:0]            w_q_frames;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_active   = r_beat_on || r_seq_on;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Pattern position, step length divisor and numerator, and the tempo sum.
    always_comb begin
        w_len  = pattern_len(r_seq_on, r_pattern);
        w_pos  = wrap_pos(r_step_pos, w_len);
        w_num  = NUM_W'(NUM_BASE) + NUM_W'(r_carry);
        w_den  = (!r_seq_on && (r_pattern == PAT_68)) ? {r_tempo, 1'b0}
                                                      : DEN_W'(r_tempo);
        w_tsum = signed'({3'b000, r_tempo})
               + {{(TEMPO_W + 3 - DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
        w_q_frames = w_quo[FL_W-1:0];
    end

    // Shared divider for the step length reload.
    dps_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Sequencer: next state and the event's effect on the mode state.
    always_comb begin
        n_state     = r_state;
        n_beat_on   = r_beat_on;
        n_seq_on    = r_seq_on;
        n_pause     = r_pause;
        n_pattern   = r_pattern;
        n_step_pos  = r_step_pos;
        n_tempo     = r_tempo;
        n_frames    = r_frames;
        n_carry     = r_carry;
        n_hit       = r_hit;
        n_voice     = r_voice;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_hit   = 1'b0;
                n_voice = V_KICK;
                n_state = ST_PUSH;
                case (r_func)
                    FN_ADVANCE: begin
                        if (w_active && !r_pause) begin
                            if (CMP_W'(r_frames) > CMP_W'(r_samples)) begin
                                n_frames = r_frames - FL_W'(r_samples);
                            end else begin
                                n_hit       = 1'b1;
                                n_voice     = pattern_voice(r_seq_on, r_pattern, w_pos);
                                n_step_pos  = (w_pos + 3'd1 == w_len) ? 3'd0 : w_pos + 3'd1;
                                w_div_start = 1'b1;
                                n_state     = ST_DIV;
                            end
                        end
                    end
                    FN_CYCLE_BEAT: begin
                        n_beat_on  = 1'b1;
                        n_pause    = 1'b0;
                        n_step_pos = 3'd0;
                        if (w_active) begin
                            n_pattern = r_pattern + 2'd1;
                        end else begin
                            n_frames = '0;
                            n_carry  = '0;
                        end
                    end
                    FN_TOGGLE_SEQ: begin
                        n_seq_on   = !r_seq_on;
                        n_pause    = 1'b0;
                        n_step_pos = 3'd0;
                        if (!w_active && !r_seq_on) begin
                            n_frames = '0;
                            n_carry  = '0;
                        end
                    end
                    FN_TOGGLE_PAUSE: begin
                        if (w_active) begin
                            n_pause = !r_pause;
                        end
                    end
                    FN_STOP: begin
                        n_beat_on  = 1'b0;
                        n_seq_on   = 1'b0;
                        n_pause    = 1'b0;
                        n_step_pos = 3'd0;
                        n_frames   = '0;
                        n_carry    = '0;
                    end
                    FN_ADJUST_TEMPO: begin
                        if (w_tsum < signed'((TEMPO_W + 3)'(BPM_MIN))) begin
                            n_tempo = TEMPO_W'(BPM_MIN);
                        end else if (w_tsum > signed'((TEMPO_W + 3)'(BPM_MAX))) begin
                            n_tempo = TEMPO_W'(BPM_MAX);
                        end else begin
                            n_tempo = w_tsum[TEMPO_W-1:0];
                        end
                    end
                    default: begin
                        n_state = ST_PUSH;
                    end
                endcase
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_frames = (w_q_frames == '0) ? FL_W'(1) : w_q_frames;
                    n_carry  = w_rem;
                    n_state  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and mode state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_beat_on  <= 1'b0;
            r_seq_on   <= 1'b0;
            r_pause    <= 1'b0;
            r_pattern  <= PAT_44;
            r_step_pos <= 3'd0;
            r_tempo    <= TEMPO_W'(BPM_RESET);
            r_frames   <= '0;
            r_carry    <= '0;
        end else begin
            r_state    <= n_state;
            r_beat_on  <= n_beat_on;
            r_seq_on   <= n_seq_on;
            r_pause    <= n_pause;
            r_pattern  <= n_pattern;
            r_step_pos <= n_step_pos;
            r_tempo    <= n_tempo;
            r_frames   <= n_frames;
            r_carry    <= n_carry;
        end
    end

    // Captured input word and the hit of the event in work.
    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_voice <= n_voice;
        if (w_accept) begin
            r_func    <= i_func;
            r_samples <= i_sample_count;
            r_delta   <= i_delta_bpm;
        end
    end

    // Output register: loaded with the status after the event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PUSH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUSH) && w_out_free) begin
            r_o_hit     <= r_hit;
            r_o_voice   <= r_voice;
            r_o_pattern <= r_pattern;
            r_o_pause   <= r_pause;
            r_o_active  <= w_active;
            r_o_seq     <= r_seq_on;
            r_o_tempo   <= r_tempo;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_voice_valid   = r_o_hit;
    assign o_voice         = r_o_voice;
    assign o_pattern_now   = r_o_pattern;
    assign o_is_paused     = r_o_pause;
    assign o_is_active     = r_o_active;
    assign o_is_sequential = r_o_seq;
    assign o_tempo_now     = r_o_tempo;

    // Tempo never leaves its clamp range.
    a_tempo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tempo >= TEMPO_W'(BPM_MIN)) && (r_tempo <= TEMPO_W'(BPM_MAX)))
        else $error("tempo outside its range");

    // The pause flag is only set while a mode is running.
    a_pause_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pause |-> (r_beat_on || r_seq_on))
        else $error("paused while stopped");

    // The step position stays inside the playing pattern.
    a_step_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_pos < w_len)
        else $error("step position beyond pattern length");

    // The divider only runs while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider busy outside the reload state");

endmodule

`default_nettype wire
